### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified implication checks for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

### hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, codes and controller/datapath types of the allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int AW         = $clog2(HEAP_DEPTH);
  localparam int CW         = AW + 1;

  localparam int SIZE_W     = 11;
  localparam int ADDR_W     = 10;
  localparam int STS_W      = 2;

  localparam logic [SIZE_W-1:0] HEAP_BYTES_RST = SIZE_W'(1024);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NO_RUN   = 2'd1,
    STS_BAD_SIZE = 2'd2,
    STS_BAD_ADDR = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_ADV,
    ST_WALK
  } state_t;

  // One entry of the byte map.
  typedef struct packed {
    logic busy;
    logic cont;
  } mark_t;

  localparam int MARK_W = $bits(mark_t);

  typedef struct packed {
    logic    accept;
    logic    clear;
    logic    scan;
    logic    mark;
    logic    adv;
    logic    walk;
    logic    res_en;
    logic    res_blk;
    status_t res_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic size_bad;
    logic heap_full;
    logic addr_bad;
    logic clr_last;
    logic run_found;
    logic run_fail;
    logic mark_last;
    logic same_start;
    logic adv_done;
    logic walk_done;
  } ctl_sts_t;

endpackage

### hw/rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: clearing pass, search, mark, pointer advance, free walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_req_type,
  output logic               busy,
  input  ffba_pkg::ctl_sts_t sts,
  output ffba_pkg::ctl_cmd_t cmd
);

  ffba_pkg::state_t state_r, state_nxt;
  logic             accept;
  logic             is_free;

  assign busy    = (state_r != ffba_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign is_free = (in_req_type == ffba_pkg::REQ_FREE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_free) begin
            if (!sts.addr_bad) state_nxt = ffba_pkg::ST_WALK;
          end else if (!sts.size_bad && !sts.heap_full) begin
            state_nxt = ffba_pkg::ST_SCAN;
          end
        end
      end
      ffba_pkg::ST_SCAN: begin
        if (sts.run_fail) begin
          state_nxt = ffba_pkg::ST_IDLE;
        end else if (sts.run_found) begin
          state_nxt = ffba_pkg::ST_MARK;
        end
      end
      ffba_pkg::ST_MARK: begin
        if (sts.mark_last) begin
          state_nxt = sts.same_start ? ffba_pkg::ST_ADV : ffba_pkg::ST_IDLE;
        end
      end
      ffba_pkg::ST_ADV: begin
        if (sts.adv_done) state_nxt = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_WALK: begin
        if (sts.walk_done) state_nxt = ffba_pkg::ST_IDLE;
      end
      default: state_nxt = ffba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.res_status = ffba_pkg::STS_OK;
    unique case (state_r)
      ffba_pkg::ST_CLEAR: cmd.clear = 1'b1;
      ffba_pkg::ST_IDLE: begin
        cmd.accept = accept;
        if (accept) begin
          if (is_free) begin
            if (sts.addr_bad) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = ffba_pkg::STS_BAD_ADDR;
            end
          end else if (sts.size_bad) begin
            cmd.res_en     = 1'b1;
            cmd.res_status = ffba_pkg::STS_BAD_SIZE;
          end else if (sts.heap_full) begin
            cmd.res_en     = 1'b1;
            cmd.res_status = ffba_pkg::STS_NO_RUN;
          end
        end
      end
      ffba_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.run_fail) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ffba_pkg::STS_NO_RUN;
        end
      end
      ffba_pkg::ST_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last && !sts.same_start) begin
          cmd.res_en  = 1'b1;
          cmd.res_blk = 1'b1;
        end
      end
      ffba_pkg::ST_ADV: begin
        cmd.adv = 1'b1;
        if (sts.adv_done) begin
          cmd.res_en  = 1'b1;
          cmd.res_blk = 1'b1;
        end
      end
      ffba_pkg::ST_WALK: begin
        cmd.walk   = 1'b1;
        cmd.res_en = sts.walk_done;
      end
      default: cmd = '0;
    endcase
  end

  // A result leaves only for a request just taken or one still in work.
  `ASSERT_IMPL(a_res_in_work, clk, rst_n, cmd.res_en, busy || accept)
  // The clearing pass runs only straight out of reset.
  `ASSERT_NEXT(a_clear_once, clk, rst_n, state_r != ffba_pkg::ST_CLEAR, state_r != ffba_pkg::ST_CLEAR)

endmodule

### hw/rtl/ffba_dpath.sv
// ----------------------------------------------------------------------------
// ffba_dpath
// Byte map, scan pointer, run counter, first-free pointer and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffba_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ffba_pkg::SIZE_W-1:0]   cfg_wr_data,
  input  logic                          in_req_type,
  input  logic [ffba_pkg::SIZE_W-1:0]   in_req_size,
  input  logic [ffba_pkg::ADDR_W-1:0]   in_req_addr,
  output logic                          out_valid,
  output logic [ffba_pkg::ADDR_W-1:0]   out_block_addr,
  output logic [ffba_pkg::STS_W-1:0]    out_status,
  input  ffba_pkg::ctl_cmd_t            cmd,
  output ffba_pkg::ctl_sts_t            sts
);

  localparam int CW = ffba_pkg::CW;
  localparam int AW = ffba_pkg::AW;

  logic [ffba_pkg::SIZE_W-1:0] heap_bytes_r;
  logic [CW-1:0]               hs;
  logic [CW-1:0]               scan_r, chk_pos_r, run_r, size_r, addr_r;
  logic [CW-1:0]               start_r, end_r, first_free_r;
  logic                        chk_vld_r;
  logic [CW-1:0]               run_inc, start_calc, chk_next;
  logic                        chk_in_heap;

  logic                        mem_we;
  logic [CW-1:0]               mem_waddr;
  ffba_pkg::mark_t             mem_wdata;
  logic [ffba_pkg::MARK_W-1:0] mem_rdata;
  ffba_pkg::mark_t             rd;

  logic                        out_valid_r;
  logic [ffba_pkg::ADDR_W-1:0] out_block_addr_r;
  ffba_pkg::status_t           out_status_r;

  assign hs = (32'(heap_bytes_r) < ffba_pkg::HEAP_DEPTH) ? CW'(heap_bytes_r)
                                                          : CW'(ffba_pkg::HEAP_DEPTH);

  assign rd          = ffba_pkg::mark_t'(mem_rdata);
  assign chk_in_heap = (chk_pos_r < hs);
  assign chk_next    = chk_pos_r + CW'(1);
  assign run_inc     = run_r + CW'(1);
  assign start_calc  = chk_next - size_r;

  always_comb begin
    sts            = '0;
    sts.size_bad   = (in_req_size == '0) || (32'(in_req_size) > 32'(hs));
    sts.heap_full  = (first_free_r >= hs);
    sts.addr_bad   = (32'(in_req_addr) >= 32'(hs));
    sts.clr_last   = (scan_r == CW'(ffba_pkg::HEAP_DEPTH - 1));
    sts.run_fail   = chk_vld_r && !chk_in_heap;
    sts.run_found  = chk_vld_r && chk_in_heap && !rd.busy && (run_inc == size_r);
    sts.mark_last  = (scan_r == end_r);
    sts.same_start = (start_r == first_free_r);
    sts.adv_done   = chk_vld_r && (!chk_in_heap || !rd.busy);
    sts.walk_done  = chk_vld_r && (!rd.cont || (chk_next >= hs));
  end

  // Map write port: clearing pass, block marking, free walk.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_r;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.mark) begin
      mem_we         = 1'b1;
      mem_wdata.busy = 1'b1;
      mem_wdata.cont = (scan_r != end_r);
    end else if (cmd.walk && chk_vld_r) begin
      mem_we         = 1'b1;
      mem_waddr      = chk_pos_r;
      mem_wdata.cont = rd.cont;
    end
  end

  ffba_ram #(
    .WIDTH (ffba_pkg::MARK_W),
    .DEPTH (ffba_pkg::HEAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (scan_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= ffba_pkg::HEAP_BYTES_RST;
      scan_r       <= '0;
      chk_vld_r    <= 1'b0;
      first_free_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) heap_bytes_r <= cfg_wr_data;

      if (cmd.accept) begin
        scan_r <= (in_req_type == ffba_pkg::REQ_FREE) ? CW'(in_req_addr) : first_free_r;
      end else if (cmd.scan && sts.run_found) begin
        scan_r <= start_calc;
      end else if (cmd.clear || cmd.scan || cmd.mark || cmd.adv || cmd.walk) begin
        scan_r <= scan_r + CW'(1);
      end

      chk_vld_r <= cmd.scan || cmd.adv || cmd.walk;

      if (cmd.adv && sts.adv_done) begin
        first_free_r <= chk_pos_r;
      end else if (cmd.walk && sts.walk_done && (addr_r < first_free_r)) begin
        first_free_r <= addr_r;
      end

      out_valid_r <= cmd.res_en;
    end
  end

  always_ff @(posedge clk) begin
    chk_pos_r <= scan_r;
    if (cmd.accept) begin
      size_r <= CW'(in_req_size);
      addr_r <= CW'(in_req_addr);
      run_r  <= '0;
    end else if (cmd.scan && chk_vld_r && chk_in_heap) begin
      run_r <= rd.busy ? '0 : run_inc;
    end
    if (cmd.scan && sts.run_found) begin
      start_r <= start_calc;
      end_r   <= chk_pos_r;
    end
    if (cmd.res_en) begin
      out_status_r     <= cmd.res_status;
      out_block_addr_r <= cmd.res_blk ? ffba_pkg::ADDR_W'(start_r) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_block_addr = out_block_addr_r;
  assign out_status     = out_status_r;

  // Marking and freeing never touch bytes past the heap end.
  `ASSERT_IMPL(a_wr_in_heap, clk, rst_n, mem_we && !cmd.clear, mem_waddr < hs)
  // The marking pointer stays inside the block that was found.
  `ASSERT_IMPL(a_mark_in_block, clk, rst_n, cmd.mark, (scan_r >= start_r) && (scan_r <= end_r))
  // A finished free leaves first_free at or below the freed offset.
  `ASSERT_NEXT(a_ff_lowered, clk, rst_n, cmd.walk && sts.walk_done, first_free_r <= addr_r)

endmodule

### hw/rtl/first_fit_byte_map_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_byte_map_allocator_unit
// Flow: a failed check returns in the cycle after start; a free clears its
//   B bytes; an allocate scans S bytes and marks its N-byte block, then
//   advances first_free over any busy bytes when the block starts on it.
// Throughput: one request at a time, one map byte per cycle; results cannot stall.
// Reset: a clearing pass over all 1024 map bytes with busy high.
// ----------------------------------------------------------------------------
module first_fit_byte_map_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ffba_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [ffba_pkg::SIZE_W-1:0] in_req_size,
  input  logic [ffba_pkg::ADDR_W-1:0] in_req_addr,
  output logic                        out_valid,
  output logic [ffba_pkg::ADDR_W-1:0] out_block_addr,
  output logic [ffba_pkg::STS_W-1:0]  out_status
);

  ffba_pkg::ctl_cmd_t cmd;
  ffba_pkg::ctl_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .busy        (busy),
    .sts         (sts),
    .cmd         (cmd)
  );

  ffba_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_req_type    (in_req_type),
    .in_req_size    (in_req_size),
    .in_req_addr    (in_req_addr),
    .out_valid      (out_valid),
    .out_block_addr (out_block_addr),
    .out_status     (out_status),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

### dv/first_fit_byte_map_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// first_fit_byte_map_allocator_unit_tb
// Drives allocate and free requests into the allocator and checks every result
// beat against a cycle-free model of the byte map, first-free pointer and heap
// size register. A directed table covers the edge cases first. Random phases
// at several heap sizes follow, with the sender stalling at random.
// ----------------------------------------------------------------------------
module first_fit_byte_map_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 40;
  localparam int QUIET_FROM  = 300;
  localparam int QUIET_TO    = 700;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    ffba_pkg::req_t              op;
    logic [ffba_pkg::SIZE_W-1:0] size;
    logic [ffba_pkg::ADDR_W-1:0] addr;
    logic                        fixed;
    logic [ffba_pkg::ADDR_W-1:0] exp_blk;
    ffba_pkg::status_t           exp_sts;
  } dir_row_t;

  typedef struct packed {
    logic [ffba_pkg::ADDR_W-1:0] blk;
    ffba_pkg::status_t           sts;
  } grant_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [ffba_pkg::SIZE_W-1:0] cfg_wr_data;
  logic                        start;
  logic                        busy;
  logic                        in_req_type;
  logic [ffba_pkg::SIZE_W-1:0] in_req_size;
  logic [ffba_pkg::ADDR_W-1:0] in_req_addr;
  logic                        out_valid;
  logic [ffba_pkg::ADDR_W-1:0] out_block_addr;
  logic [ffba_pkg::STS_W-1:0]  out_status;

  // Model of the allocator state
  bit                          byte_busy [ffba_pkg::HEAP_DEPTH];
  bit                          byte_cont [ffba_pkg::HEAP_DEPTH];
  int unsigned                 first_free;
  logic [ffba_pkg::SIZE_W-1:0] heap_bytes;

  grant_t            grants_due [$];
  int unsigned       live_blocks [$];
  bit                failed;
  int unsigned       sent;
  int unsigned       stall_cnt;

  // Directed part: typed expectations only where they are obvious
  dir_row_t dir_tab [0:28] = '{
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd0,    10'd0,    1'b1, 10'd0, ffba_pkg::STS_BAD_SIZE},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd1025, 10'd0,    1'b1, 10'd0, ffba_pkg::STS_BAD_SIZE},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd2047, 10'd1023, 1'b1, 10'd0, ffba_pkg::STS_BAD_SIZE},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd1,    10'd0,    1'b1, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd3,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd1,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd2,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd2047, 10'd1023, 1'b1, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd1024, 10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd1,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd1024, 10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd1,    10'd0,    1'b1, 10'd0, ffba_pkg::STS_NO_RUN},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd512,  1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd512,  10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_CFG, ffba_pkg::REQ_ALLOC, 11'd0,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd1,    10'd0,    1'b1, 10'd0, ffba_pkg::STS_BAD_SIZE},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd0,    1'b1, 10'd0, ffba_pkg::STS_BAD_ADDR},
    '{ROW_CFG, ffba_pkg::REQ_ALLOC, 11'd2047, 10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_CFG, ffba_pkg::REQ_ALLOC, 11'd4,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd4,    1'b1, 10'd0, ffba_pkg::STS_BAD_ADDR},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd4,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd5,    10'd0,    1'b1, 10'd0, ffba_pkg::STS_BAD_SIZE},
    '{ROW_CFG, ffba_pkg::REQ_ALLOC, 11'd2,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_FREE,  11'd0,    10'd1023, 1'b1, 10'd0, ffba_pkg::STS_BAD_ADDR},
    '{ROW_CFG, ffba_pkg::REQ_ALLOC, 11'd1024, 10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK},
    '{ROW_REQ, ffba_pkg::REQ_ALLOC, 11'd1024, 10'd0,    1'b0, 10'd0, ffba_pkg::STS_OK}
  };

  // Random phases: most at small heaps, a few at full depth
  int unsigned phase_heap  [12] = '{64, 1024, 16, 200, 1, 2047, 128, 0, 4, 37, 1024, 500};
  int unsigned phase_items [12] = '{250, 120, 150, 200, 60, 100, 250, 30, 80, 200, 80, 150};

  first_fit_byte_map_allocator_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_req_size    (in_req_size),
    .in_req_addr    (in_req_addr),
    .out_valid      (out_valid),
    .out_block_addr (out_block_addr),
    .out_status     (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned heap_span();
    return (heap_bytes < ffba_pkg::HEAP_DEPTH) ? int'(heap_bytes) : ffba_pkg::HEAP_DEPTH;
  endfunction

  // Apply one request to the model and return the grant it produces
  function automatic grant_t calc_grant(ffba_pkg::req_t op,
                                        logic [ffba_pkg::SIZE_W-1:0] size,
                                        logic [ffba_pkg::ADDR_W-1:0] addr);
    grant_t      g;
    int unsigned hs;
    int unsigned pos;
    int unsigned run;
    int unsigned blk_start;
    int unsigned i;
    bit          found;
    bit          done;
    g.blk = '0;
    g.sts = ffba_pkg::STS_OK;
    hs    = heap_span();
    run   = 0;
    found = 1'b0;
    done  = 1'b0;
    if (op == ffba_pkg::REQ_ALLOC) begin
      if (size == 0 || size > hs) begin
        g.sts = ffba_pkg::STS_BAD_SIZE;
      end else if (first_free >= hs) begin
        g.sts = ffba_pkg::STS_NO_RUN;
      end else begin
        for (pos = first_free; pos < hs; pos++) begin
          if (byte_busy[pos]) begin
            run = 0;
          end else begin
            run++;
            if (run == size) begin
              found = 1'b1;
              break;
            end
          end
        end
        if (!found) begin
          g.sts = ffba_pkg::STS_NO_RUN;
        end else begin
          blk_start = pos + 1 - size;
          for (i = blk_start; i <= pos; i++) begin
            byte_busy[i] = 1'b1;
            byte_cont[i] = 1'b1;
          end
          byte_cont[pos] = 1'b0;
          // Advance the pointer only when the block sits right on it
          if (blk_start == first_free) begin
            i = pos + 1;
            while (i < hs && byte_busy[i]) i++;
            first_free = i;
          end
          g.blk = ffba_pkg::ADDR_W'(blk_start);
        end
      end
    end else begin
      if (addr >= hs) begin
        g.sts = ffba_pkg::STS_BAD_ADDR;
      end else begin
        pos = addr;
        while (!done) begin
          byte_busy[pos] = 1'b0;
          if (!byte_cont[pos]) begin
            done = 1'b1;
          end else begin
            pos++;
            if (pos >= hs) done = 1'b1;
          end
        end
        if (addr < first_free) first_free = addr;
      end
    end
    return g;
  endfunction

  // Hold the request until the block takes it, then log what it must return
  task automatic issue(ffba_pkg::req_t op, logic [ffba_pkg::SIZE_W-1:0] size,
                       logic [ffba_pkg::ADDR_W-1:0] addr, bit fixed, grant_t fixed_g);
    grant_t g;
    start       <= 1'b1;
    in_req_type <= op;
    in_req_size <= size;
    in_req_addr <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    g = calc_grant(op, size, addr);
    if (op == ffba_pkg::REQ_ALLOC && g.sts == ffba_pkg::STS_OK) live_blocks.push_back(g.blk);
    grants_due.push_back(fixed ? fixed_g : g);
    sent++;
  endtask

  // Drop start and hold off until every outstanding grant is back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (grants_due.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_heap(logic [ffba_pkg::SIZE_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    heap_bytes = value;
    cfg_wr_en  <= 1'b0;
  endtask

  task automatic idle_gap();
    if ((sent < QUIET_FROM || sent >= QUIET_TO) && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // Mostly sane sizes and frees of live blocks, with some junk mixed in
  task automatic pick_item(int unsigned hs, output ffba_pkg::req_t op,
                           output logic [ffba_pkg::SIZE_W-1:0] sz,
                           output logic [ffba_pkg::ADDR_W-1:0] ad);
    int unsigned roll;
    int unsigned idx;
    int unsigned cap;
    cap  = (hs < 6) ? 1 : hs / 6;
    sz   = ffba_pkg::SIZE_W'($urandom_range(0, 2047));
    ad   = ffba_pkg::ADDR_W'($urandom_range(0, 1023));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      op   = ffba_pkg::REQ_ALLOC;
      roll = $urandom_range(0, 99);
      if (roll < 70) sz = ffba_pkg::SIZE_W'($urandom_range(1, cap));
      else if (roll < 85) sz = ffba_pkg::SIZE_W'($urandom_range(1, (hs > 1) ? hs : 1));
      else if (roll < 90) sz = '0;
      else if (roll < 95) sz = ffba_pkg::SIZE_W'($urandom_range(hs + 1, 2047));
    end else begin
      op = ffba_pkg::REQ_FREE;
      if (live_blocks.size() != 0 && $urandom_range(0, 99) < 80) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        ad  = ffba_pkg::ADDR_W'(live_blocks[idx]);
        live_blocks.delete(idx);
      end
    end
  endtask

  // Result beats cannot be held off: compare each one as it goes by
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid) begin
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result beat: block_addr=%0d status=%0d",
                 $time, out_block_addr, out_status);
        failed = 1'b1;
      end else begin
        g = grants_due.pop_front();
        if (out_block_addr !== g.blk) begin
          $display("%0t: block_addr mismatch: expected %0d, actual %0d",
                   $time, g.blk, out_block_addr);
          failed = 1'b1;
        end
        if (out_status !== g.sts) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, g.sts, out_status);
          failed = 1'b1;
        end
      end
    end
  end

  // Only an accepted request or an expected result beat counts as progress
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || (out_valid === 1'b1 && grants_due.size() != 0))
      stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL first_fit_byte_map_allocator_unit");
      $finish;
    end
  end

  initial begin
    ffba_pkg::req_t              op;
    logic [ffba_pkg::SIZE_W-1:0] sz;
    logic [ffba_pkg::ADDR_W-1:0] ad;
    int unsigned                 hs;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_req_type <= ffba_pkg::REQ_ALLOC;
    in_req_size <= '0;
    in_req_addr <= '0;
    heap_bytes  = ffba_pkg::HEAP_BYTES_RST;
    first_free  = 0;
    failed      = 1'b0;
    sent        = 0;
    stall_cnt   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        write_heap(dir_tab[r].size);
      end else begin
        issue(dir_tab[r].op, dir_tab[r].size, dir_tab[r].addr, dir_tab[r].fixed,
              '{dir_tab[r].exp_blk, dir_tab[r].exp_sts});
      end
    end

    foreach (phase_heap[p]) begin
      write_heap(ffba_pkg::SIZE_W'(phase_heap[p]));
      hs = heap_span();
      repeat (phase_items[p]) begin
        pick_item(hs, op, sz, ad);
        issue(op, sz, ad, 1'b0, '0);
        idle_gap();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed) $display("PASS first_fit_byte_map_allocator_unit");
    else $display("FAIL first_fit_byte_map_allocator_unit");
    $finish;
  end

endmodule
